FILE: hdl/salc_pkg.sv
// Package: cache geometry, row layout, controller command type.
package salc_pkg;

	localparam int CACHE_LOG2 = 15;
	localparam int BLOCK_LOG2 = 5;
	localparam int WAYS_LOG2  = 2;

	localparam int ADDR_W    = 64;
	localparam int WAY_OUT_W = 4;
	localparam int SET_LOG2  = CACHE_LOG2 - BLOCK_LOG2 - WAYS_LOG2;
	localparam int NUM_SETS  = 1 << SET_LOG2;
	localparam int NUM_WAYS  = 1 << WAYS_LOG2;
	localparam int TAG_SHIFT = BLOCK_LOG2 + SET_LOG2;
	localparam int TAG_W     = ADDR_W - TAG_SHIFT;
	localparam int SET_W     = (SET_LOG2 > 0) ? SET_LOG2 : 1;
	localparam int WAY_W     = (WAYS_LOG2 > 0) ? WAYS_LOG2 : 1;

	typedef logic [TAG_W-1:0] tag_t;
	typedef logic [SET_W-1:0] set_t;
	typedef logic [WAY_W-1:0] way_t;

	typedef struct packed {
		tag_t [NUM_WAYS-1:0]    tags;
		logic [NUM_WAYS-1:0]    valid;
		logic [NUM_WAYS-1:0]    dirty;
		way_t [NUM_WAYS-1:0]    ranks;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	function automatic row_t reset_row();
		row_t r;
		r = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			r.ranks[w] = WAY_W'(w);
		end
		return r;
	endfunction

endpackage

FILE: hdl/salc_ifs.sv
// Request and response channel interfaces.
interface salc_req_if;
	import salc_pkg::*;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output kind, output address, input ready);
	modport sink (input valid, input kind, input address, output ready);
endinterface

interface salc_rsp_if;
	import salc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 writeback_needed;
	logic [WAY_OUT_W-1:0] way_used;

	modport source (output valid, output hit, output writeback_needed, output way_used,
		input ready);
	modport sink (input valid, input hit, input writeback_needed, input way_used,
		output ready);
endinterface

FILE: hdl/salc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: hdl/salc_ctrl.sv
// Controller: request/response handshake and lookup sequencing.
module salc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output salc_pkg::cmd_t  cmd
);
	import salc_pkg::*;

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_LOOKUP = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_capture_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_LOOKUP) else $error("capture did not start lookup");
	a_commit_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q) else $error("commit lost response");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q) else $error("response dropped");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.commit)) else $error("capture during commit");
endmodule

FILE: hdl/salc_dp.sv
// Datapath: address split, tag/state row lookup, LRU update, response register.
module salc_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  salc_pkg::cmd_t                 cmd,
	input  logic                           kind,
	input  logic [salc_pkg::ADDR_W-1:0]    address,
	output logic                           hit,
	output logic                           writeback_needed,
	output logic [salc_pkg::WAY_OUT_W-1:0] way_used
);
	import salc_pkg::*;

	logic                 kind_s1;
	tag_t                 tag_s1;
	set_t                 set_s1;
	set_t                 rd_set;
	logic [ROW_W-1:0]     rd_data;
	logic [NUM_SETS-1:0]  row_init_q;
	row_t                 row;
	row_t                 nrow;
	logic                 hit_any;
	logic                 free_any;
	way_t                 hit_way;
	way_t                 free_way;
	way_t                 lru_way;
	way_t                 sel_way;
	way_t                 old_rank;
	logic                 wb;
	logic                 hit_q;
	logic                 wb_q;
	way_t                 way_q;

	assign rd_set = SET_W'((address >> BLOCK_LOG2) & ADDR_W'(NUM_SETS - 1));

	salc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_row_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (set_s1),
		.wdata (nrow),
		.re    (cmd.capture),
		.raddr (rd_set),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_s1 <= kind;
			tag_s1  <= TAG_W'(address >> TAG_SHIFT);
			set_s1  <= rd_set;
		end
		if (cmd.commit) begin
			hit_q <= hit_any;
			wb_q  <= wb;
			way_q <= sel_way;
		end
	end

	// a set never written reads as its reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
		end else if (cmd.commit) begin
			row_init_q[set_s1] <= 1'b1;
		end
	end

	always_comb begin
		row      = row_init_q[set_s1] ? row_t'(rd_data) : reset_row();
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_way  = '0;
		free_way = '0;
		lru_way  = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row.valid[w] && (row.tags[w] == tag_s1)) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!row.valid[w]) begin
				free_any = 1'b1;
				free_way = WAY_W'(w);
			end
			if (row.ranks[w] == WAY_W'(NUM_WAYS - 1)) begin
				lru_way = WAY_W'(w);
			end
		end
		sel_way  = hit_any ? hit_way : (free_any ? free_way : lru_way);
		wb       = !hit_any && !free_any && row.dirty[sel_way];
		old_rank = row.ranks[sel_way];

		nrow = row;
		if (hit_any) begin
			nrow.dirty[sel_way] = row.dirty[sel_way] | kind_s1;
		end else begin
			nrow.tags[sel_way]  = tag_s1;
			nrow.dirty[sel_way] = kind_s1;
		end
		nrow.valid[sel_way] = 1'b1;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (row.ranks[w] < old_rank) begin
				nrow.ranks[w] = WAY_W'(row.ranks[w] + 1'b1);
			end
		end
		nrow.ranks[sel_way] = '0;
	end

	assign hit              = hit_q;
	assign writeback_needed = wb_q;
	assign way_used         = WAY_OUT_W'(way_q);
endmodule

FILE: hdl/set_assoc_lru_writeback_cache.sv
// Top level: set-associative write-back LRU cache tag controller.
// Flow: an accepted request is registered and its per-set row RAM entry is read;
//   commit then loads the response register and writes back the updated tags, dirty
//   bits and LRU ranks, waiting while a response is held; next request after commit.
// The response register lets a new request enter while the last response waits.
// Reset: arst_n clears the controller and the per-set init flags; no clearing pass.
module set_assoc_lru_writeback_cache (
	input logic       clk,
	input logic       arst_n,
	salc_req_if.sink  req,
	salc_rsp_if.source rsp
);
	import salc_pkg::*;

	cmd_t cmd;

	salc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	salc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.kind             (req.kind),
		.address          (req.address),
		.hit              (rsp.hit),
		.writeback_needed (rsp.writeback_needed),
		.way_used         (rsp.way_used)
	);
endmodule
